// ===== design/burgers_fd_rhs_jacobian_row_unit_assert.svh =====
// Assertion macros used by the checker file of the row unit.
`ifndef BURGERS_FD_RHS_JACOBIAN_ROW_UNIT_ASSERT_SVH
`define BURGERS_FD_RHS_JACOBIAN_ROW_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define BFJ_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define BFJ_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/bfj_pkg.sv =====
// Shared types, constants and codes of the Burgers row unit.
package bfj_pkg;

	localparam int MAX_POINTS = 4096;
	localparam int VALUE_W    = 32;
	localparam int GAIN_W     = 31;
	localparam int ROW_IDX_W  = 12;
	localparam logic [ROW_IDX_W-1:0] LAST_IDX = ROW_IDX_W'(MAX_POINTS - 1);

	// fixed point: values Q16.16, gains unsigned Q7.24
	localparam int FRAC_VALUE   = 16;
	localparam int SHIFT_NARROW = 24;
	localparam int SHIFT_WIDE   = 40;
	localparam int JD_SHIFT     = SHIFT_NARROW - FRAC_VALUE;
	localparam int JD2_SHIFT    = JD_SHIFT - 1;

	localparam logic signed [VALUE_W-1:0] VMAX = {1'b0, {(VALUE_W-1){1'b1}}};
	localparam logic signed [VALUE_W-1:0] VMIN = {1'b1, {(VALUE_W-1){1'b0}}};
	localparam logic signed [VALUE_W-1:0] ONE_Q16 = VALUE_W'(1) << FRAC_VALUE;

	// shared multiplier and product widths
	localparam int MUL_A_W  = VALUE_W + 2;
	localparam int MUL_B_W  = VALUE_W;
	localparam int PROD_W   = MUL_A_W + MUL_B_W;
	localparam int SQ_W     = 2 * VALUE_W - 1;
	localparam int WIDE_W   = 3 * VALUE_W;
	localparam int SCALED_W = WIDE_W - SHIFT_NARROW;
	localparam logic [SCALED_W-1:0] POS_LIMIT = {{(SCALED_W-VALUE_W+1){1'b0}},
		{(VALUE_W-1){1'b1}}};
	localparam logic [SCALED_W-1:0] NEG_LIMIT = SCALED_W'(1) << (VALUE_W - 1);

	// job queue
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// configuration port
	localparam int NUM_REGS = 5;
	localparam int ADDR_W   = $clog2(4 * NUM_REGS);
	localparam int PDATA_W  = 32;

	typedef enum logic [ADDR_W-3:0] {
		REG_DIFF_GAIN    = 0,
		REG_ADV_GAIN     = 1,
		REG_STEP_GAIN    = 2,
		REG_JAC_DIFF_GAIN = 3,
		REG_JAC_ADV_GAIN = 4
	} reg_index_t;

	typedef struct packed {
		logic signed [VALUE_W-1:0] grid_value;
		logic signed [VALUE_W-1:0] source_value;
		logic                      is_last;
	} in_item_t;

	typedef struct packed {
		logic [ROW_IDX_W-1:0]      row_index;
		logic signed [VALUE_W-1:0] rhs_value;
		logic signed [VALUE_W-1:0] jac_lower;
		logic signed [VALUE_W-1:0] jac_diag;
		logic signed [VALUE_W-1:0] jac_upper;
		logic                      row_last;
	} out_item_t;

	// one row to evaluate: stencil left/center/right, source at center
	typedef struct packed {
		logic [ROW_IDX_W-1:0]      idx;
		logic signed [VALUE_W-1:0] left;
		logic signed [VALUE_W-1:0] center;
		logic signed [VALUE_W-1:0] right;
		logic signed [VALUE_W-1:0] src;
		logic                      fin;
	} job_t;

	typedef struct packed {
		logic [GAIN_W-1:0] diff_gain;
		logic [GAIN_W-1:0] adv_gain;
		logic [GAIN_W-1:0] step_gain;
		logic [GAIN_W-1:0] jac_diff_gain;
		logic [GAIN_W-1:0] jac_adv_gain;
	} gains_t;

	typedef struct packed {
		logic empty;
		logic full;
	} queue_status_t;

	typedef enum logic [2:0] {
		F_IDLE,
		F_MID,
		F_END,
		F_WRAP,
		F_SINGLE
	} front_state_t;

	typedef enum logic [3:0] {
		B_IDLE,
		B_PREP,
		B_RR,
		B_LL,
		B_LAP,
		B_SQLO,
		B_SQHI,
		B_SRC,
		B_JL,
		B_JR,
		B_DRAIN,
		B_WRITE
	} back_state_t;

endpackage

// ===== design/bfj_queue.sv =====
// Small register FIFO of row jobs between the front and back ends.
module bfj_queue (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	input  bfj_pkg::job_t          push_job,
	input  logic                   pop,
	output bfj_pkg::job_t          head,
	output bfj_pkg::queue_status_t status
);

	bfj_pkg::job_t                  mem_q [bfj_pkg::QUEUE_DEPTH];
	logic [bfj_pkg::QPTR_W-1:0]     wr_ptr_q;
	logic [bfj_pkg::QPTR_W-1:0]     rd_ptr_q;
	logic [bfj_pkg::QCNT_W-1:0]     cnt_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	assign head         = mem_q[rd_ptr_q];
	assign status.empty = (cnt_q == '0);
	assign status.full  = (cnt_q == bfj_pkg::QCNT_W'(bfj_pkg::QUEUE_DEPTH));

endmodule

// ===== design/bfj_front.sv =====
// Front end: takes grid points, keeps the periodic window, issues row jobs.
module bfj_front (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  bfj_pkg::in_item_t      in_data,
	input  bfj_pkg::queue_status_t q_status,
	output logic                   push,
	output bfj_pkg::job_t          push_job
);

	bfj_pkg::front_state_t            state_q, state_d;
	logic [bfj_pkg::ROW_IDX_W-1:0]    count_q, pj_q;
	logic signed [bfj_pkg::VALUE_W-1:0] first_q, second_q, first_src_q;
	logic signed [bfj_pkg::VALUE_W-1:0] older_q, newer_q, newer_src_q;
	logic signed [bfj_pkg::VALUE_W-1:0] pu_q, pe_q;
	logic                             plast_q;
	logic                             accept, last_in, low_count;
	logic                             shift_now, shift_late, close;

	assign accept    = in_valid && (state_q == bfj_pkg::F_IDLE);
	assign last_in   = in_data.is_last || (count_q == bfj_pkg::LAST_IDX);
	assign low_count = (count_q[bfj_pkg::ROW_IDX_W-1:1] == '0);

	// window advance: right at accept when the point yields no row, or after
	// the interior row of a point that does not close the vector
	assign shift_now  = accept && !last_in && low_count;
	assign shift_late = (state_q == bfj_pkg::F_MID) && !q_status.full && !plast_q;
	assign close      = ((state_q == bfj_pkg::F_WRAP) || (state_q == bfj_pkg::F_SINGLE))
		&& !q_status.full;

	always_comb begin
		state_d = state_q;
		case (state_q)
			bfj_pkg::F_IDLE: begin
				if (accept) begin
					if ((count_q == '0) && last_in) begin
						state_d = bfj_pkg::F_SINGLE;
					end else if (!low_count) begin
						state_d = bfj_pkg::F_MID;
					end else if (last_in) begin
						state_d = bfj_pkg::F_END;
					end
				end
			end
			bfj_pkg::F_MID: begin
				if (!q_status.full) begin
					state_d = plast_q ? bfj_pkg::F_END : bfj_pkg::F_IDLE;
				end
			end
			bfj_pkg::F_END: begin
				if (!q_status.full) begin
					state_d = bfj_pkg::F_WRAP;
				end
			end
			bfj_pkg::F_WRAP, bfj_pkg::F_SINGLE: begin
				if (!q_status.full) begin
					state_d = bfj_pkg::F_IDLE;
				end
			end
			default: state_d = bfj_pkg::F_IDLE;
		endcase
	end

	always_comb begin
		push     = (state_q != bfj_pkg::F_IDLE) && !q_status.full;
		in_stall = (state_q != bfj_pkg::F_IDLE);
		push_job = '0;
		case (state_q)
			bfj_pkg::F_MID: begin
				push_job.idx    = pj_q - 1'b1;
				push_job.left   = older_q;
				push_job.center = newer_q;
				push_job.right  = pu_q;
				push_job.src    = newer_src_q;
				push_job.fin    = 1'b0;
			end
			bfj_pkg::F_END: begin
				push_job.idx    = pj_q;
				push_job.left   = newer_q;
				push_job.center = pu_q;
				push_job.right  = first_q;
				push_job.src    = pe_q;
				push_job.fin    = 1'b0;
			end
			bfj_pkg::F_WRAP: begin
				push_job.idx    = '0;
				push_job.left   = pu_q;
				push_job.center = first_q;
				push_job.right  = second_q;
				push_job.src    = first_src_q;
				push_job.fin    = 1'b1;
			end
			bfj_pkg::F_SINGLE: begin
				push_job.idx    = '0;
				push_job.left   = pu_q;
				push_job.center = pu_q;
				push_job.right  = pu_q;
				push_job.src    = pe_q;
				push_job.fin    = 1'b1;
			end
			default: push_job = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bfj_pkg::F_IDLE;
			count_q <= '0;
		end else begin
			state_q <= state_d;
			if (shift_now) begin
				count_q <= count_q + 1'b1;
			end else if (shift_late) begin
				count_q <= pj_q + 1'b1;
			end else if (close) begin
				count_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pu_q    <= in_data.grid_value;
			pe_q    <= in_data.source_value;
			plast_q <= last_in;
			pj_q    <= count_q;
			if (count_q == '0) begin
				first_q     <= in_data.grid_value;
				first_src_q <= in_data.source_value;
			end
			if (count_q == bfj_pkg::ROW_IDX_W'(1)) begin
				second_q <= in_data.grid_value;
			end
		end
		if (shift_now) begin
			older_q     <= newer_q;
			newer_q     <= in_data.grid_value;
			newer_src_q <= in_data.source_value;
		end else if (shift_late) begin
			older_q     <= newer_q;
			newer_q     <= pu_q;
			newer_src_q <= pe_q;
		end
	end

endmodule

// ===== design/bfj_back.sv =====
// Back end: evaluates one row job on a shared multiplier, holds the result.
module bfj_back (
	input  logic                   clk,
	input  logic                   arst_n,
	input  bfj_pkg::gains_t        gains,
	input  bfj_pkg::job_t          q_head,
	input  bfj_pkg::queue_status_t q_status,
	output logic                   q_pop,
	output logic                   out_valid,
	input  logic                   out_stall,
	output bfj_pkg::out_item_t     out_data
);

	function automatic logic [bfj_pkg::VALUE_W-1:0] mag_value(
		input logic signed [bfj_pkg::VALUE_W-1:0] a);
		return a[bfj_pkg::VALUE_W-1] ? bfj_pkg::VALUE_W'(-a) : bfj_pkg::VALUE_W'(a);
	endfunction

	// floor of a signed product shifted to Q16.16, saturated
	function automatic logic signed [bfj_pkg::VALUE_W-1:0] scale_sat(
		input logic [bfj_pkg::WIDE_W-1:0] p, input logic neg, input logic wide);
		logic [bfj_pkg::SCALED_W-1:0]      q;
		logic                              rem;
		logic signed [bfj_pkg::VALUE_W-1:0] res;
		q   = wide ? bfj_pkg::SCALED_W'(p >> bfj_pkg::SHIFT_WIDE)
			: bfj_pkg::SCALED_W'(p >> bfj_pkg::SHIFT_NARROW);
		rem = wide ? (p[bfj_pkg::SHIFT_WIDE-1:0] != '0)
			: (p[bfj_pkg::SHIFT_NARROW-1:0] != '0);
		if (neg && rem) begin
			q = q + 1'b1;
		end
		if (!neg) begin
			res = (q > bfj_pkg::POS_LIMIT) ? bfj_pkg::VMAX : q[bfj_pkg::VALUE_W-1:0];
		end else begin
			res = (q > bfj_pkg::NEG_LIMIT) ? bfj_pkg::VMIN : -q[bfj_pkg::VALUE_W-1:0];
		end
		return res;
	endfunction

	function automatic logic signed [bfj_pkg::VALUE_W-1:0] sat_add(
		input logic signed [bfj_pkg::VALUE_W-1:0] a,
		input logic signed [bfj_pkg::VALUE_W-1:0] b);
		logic signed [bfj_pkg::VALUE_W:0] s;
		s = (bfj_pkg::VALUE_W+1)'(a) + (bfj_pkg::VALUE_W+1)'(b);
		if (s[bfj_pkg::VALUE_W] != s[bfj_pkg::VALUE_W-1]) begin
			return s[bfj_pkg::VALUE_W] ? bfj_pkg::VMIN : bfj_pkg::VMAX;
		end
		return s[bfj_pkg::VALUE_W-1:0];
	endfunction

	function automatic logic signed [bfj_pkg::VALUE_W-1:0] sat_sub(
		input logic signed [bfj_pkg::VALUE_W-1:0] a,
		input logic signed [bfj_pkg::VALUE_W-1:0] b);
		logic signed [bfj_pkg::VALUE_W:0] s;
		s = (bfj_pkg::VALUE_W+1)'(a) - (bfj_pkg::VALUE_W+1)'(b);
		if (s[bfj_pkg::VALUE_W] != s[bfj_pkg::VALUE_W-1]) begin
			return s[bfj_pkg::VALUE_W] ? bfj_pkg::VMIN : bfj_pkg::VMAX;
		end
		return s[bfj_pkg::VALUE_W-1:0];
	endfunction

	bfj_pkg::back_state_t                state_q, state_d, op_s1;
	bfj_pkg::job_t                       job_q;
	logic [bfj_pkg::VALUE_W-1:0]         l_mag_q, r_mag_q, src_mag_q;
	logic                                l_neg_q, r_neg_q, src_neg_q;
	logic [bfj_pkg::MUL_A_W-1:0]         lap_mag_q;
	logic                                lap_neg_q;
	logic [bfj_pkg::SQ_W-1:0]            rr_q, sq_mag_q, lo_q;
	logic                                sq_neg_q;
	logic signed [bfj_pkg::VALUE_W-1:0]  t_lap_q, t_sq_q, t_src_q, t_l_q, t_r_q;
	logic [bfj_pkg::MUL_A_W-1:0]         mul_a;
	logic [bfj_pkg::MUL_B_W-1:0]         mul_b;
	logic                                mul_neg, neg_s1;
	logic [bfj_pkg::PROD_W-1:0]          mul_p, prod_s1;
	logic                                write_out, out_valid_q;
	bfj_pkg::out_item_t                  out_data_q;
	logic signed [bfj_pkg::MUL_A_W-1:0]  lap;
	logic [2*bfj_pkg::VALUE_W-1:0]       sq_diff, sq_abs;
	logic [bfj_pkg::WIDE_W-1:0]          sq_full;
	logic signed [bfj_pkg::VALUE_W-1:0]  ndj, rhs, lower, upper, diag;

	assign lap = bfj_pkg::MUL_A_W'(job_q.left) - bfj_pkg::MUL_A_W'(job_q.center)
		- bfj_pkg::MUL_A_W'(job_q.center) + bfj_pkg::MUL_A_W'(job_q.right);

	always_comb begin
		state_d = state_q;
		case (state_q)
			bfj_pkg::B_IDLE:  if (!q_status.empty) state_d = bfj_pkg::B_PREP;
			bfj_pkg::B_PREP:  state_d = bfj_pkg::B_RR;
			bfj_pkg::B_RR:    state_d = bfj_pkg::B_LL;
			bfj_pkg::B_LL:    state_d = bfj_pkg::B_LAP;
			bfj_pkg::B_LAP:   state_d = bfj_pkg::B_SQLO;
			bfj_pkg::B_SQLO:  state_d = bfj_pkg::B_SQHI;
			bfj_pkg::B_SQHI:  state_d = bfj_pkg::B_SRC;
			bfj_pkg::B_SRC:   state_d = bfj_pkg::B_JL;
			bfj_pkg::B_JL:    state_d = bfj_pkg::B_JR;
			bfj_pkg::B_JR:    state_d = bfj_pkg::B_DRAIN;
			bfj_pkg::B_DRAIN: state_d = bfj_pkg::B_WRITE;
			bfj_pkg::B_WRITE: if (write_out) state_d = bfj_pkg::B_IDLE;
			default:          state_d = bfj_pkg::B_IDLE;
		endcase
	end

	// operand select for the shared multiplier, queue pop, result write
	always_comb begin
		mul_a     = '0;
		mul_b     = '0;
		mul_neg   = 1'b0;
		q_pop     = 1'b0;
		write_out = 1'b0;
		case (state_q)
			bfj_pkg::B_IDLE: q_pop = !q_status.empty;
			bfj_pkg::B_RR: begin
				mul_a = bfj_pkg::MUL_A_W'(r_mag_q);
				mul_b = bfj_pkg::MUL_B_W'(r_mag_q);
			end
			bfj_pkg::B_LL: begin
				mul_a = bfj_pkg::MUL_A_W'(l_mag_q);
				mul_b = bfj_pkg::MUL_B_W'(l_mag_q);
			end
			bfj_pkg::B_LAP: begin
				mul_a   = lap_mag_q;
				mul_b   = bfj_pkg::MUL_B_W'(gains.diff_gain);
				mul_neg = lap_neg_q;
			end
			bfj_pkg::B_SQLO: begin
				mul_a   = bfj_pkg::MUL_A_W'(sq_mag_q[bfj_pkg::VALUE_W-1:0]);
				mul_b   = bfj_pkg::MUL_B_W'(gains.adv_gain);
				mul_neg = sq_neg_q;
			end
			bfj_pkg::B_SQHI: begin
				mul_a   = bfj_pkg::MUL_A_W'(sq_mag_q[bfj_pkg::SQ_W-1:bfj_pkg::VALUE_W]);
				mul_b   = bfj_pkg::MUL_B_W'(gains.adv_gain);
				mul_neg = sq_neg_q;
			end
			bfj_pkg::B_SRC: begin
				mul_a   = bfj_pkg::MUL_A_W'(src_mag_q);
				mul_b   = bfj_pkg::MUL_B_W'(gains.step_gain);
				mul_neg = src_neg_q;
			end
			bfj_pkg::B_JL: begin
				mul_a   = bfj_pkg::MUL_A_W'(l_mag_q);
				mul_b   = bfj_pkg::MUL_B_W'(gains.jac_adv_gain);
				mul_neg = l_neg_q;
			end
			bfj_pkg::B_JR: begin
				mul_a   = bfj_pkg::MUL_A_W'(r_mag_q);
				mul_b   = bfj_pkg::MUL_B_W'(gains.jac_adv_gain);
				mul_neg = r_neg_q;
			end
			bfj_pkg::B_WRITE: write_out = !out_valid_q || !out_stall;
			default: begin
				mul_a = '0;
			end
		endcase
	end

	assign mul_p = mul_a * mul_b;

	assign sq_diff = (2*bfj_pkg::VALUE_W)'(rr_q)
		- (2*bfj_pkg::VALUE_W)'(prod_s1[bfj_pkg::SQ_W-1:0]);
	assign sq_abs  = sq_diff[2*bfj_pkg::VALUE_W-1] ? -sq_diff : sq_diff;
	assign sq_full = (bfj_pkg::WIDE_W'(prod_s1) << bfj_pkg::VALUE_W)
		+ bfj_pkg::WIDE_W'(lo_q);

	assign ndj   = -bfj_pkg::VALUE_W'(gains.jac_diff_gain >> bfj_pkg::JD_SHIFT);
	assign rhs   = sat_sub(sat_sub(t_lap_q, t_sq_q), t_src_q);
	assign lower = sat_sub(ndj, t_l_q);
	assign upper = sat_add(ndj, t_r_q);
	assign diag  = bfj_pkg::ONE_Q16
		+ bfj_pkg::VALUE_W'(gains.jac_diff_gain >> bfj_pkg::JD2_SHIFT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= bfj_pkg::B_IDLE;
			op_s1       <= bfj_pkg::B_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			op_s1   <= state_q;
			if (write_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			job_q <= q_head;
		end
		if (state_q == bfj_pkg::B_PREP) begin
			l_mag_q   <= mag_value(job_q.left);
			l_neg_q   <= job_q.left[bfj_pkg::VALUE_W-1];
			r_mag_q   <= mag_value(job_q.right);
			r_neg_q   <= job_q.right[bfj_pkg::VALUE_W-1];
			src_mag_q <= mag_value(job_q.src);
			src_neg_q <= job_q.src[bfj_pkg::VALUE_W-1];
			lap_mag_q <= lap[bfj_pkg::MUL_A_W-1] ? bfj_pkg::MUL_A_W'(-lap)
				: bfj_pkg::MUL_A_W'(lap);
			lap_neg_q <= lap[bfj_pkg::MUL_A_W-1];
		end
		prod_s1 <= mul_p;
		neg_s1  <= mul_neg;
		// post stage: scale the product issued in the previous cycle
		case (op_s1)
			bfj_pkg::B_RR: rr_q <= prod_s1[bfj_pkg::SQ_W-1:0];
			bfj_pkg::B_LL: begin
				sq_mag_q <= sq_abs[bfj_pkg::SQ_W-1:0];
				sq_neg_q <= sq_diff[2*bfj_pkg::VALUE_W-1];
			end
			bfj_pkg::B_LAP:  t_lap_q <= scale_sat(bfj_pkg::WIDE_W'(prod_s1), neg_s1, 1'b0);
			bfj_pkg::B_SQLO: lo_q    <= prod_s1[bfj_pkg::SQ_W-1:0];
			bfj_pkg::B_SQHI: t_sq_q  <= scale_sat(sq_full, neg_s1, 1'b1);
			bfj_pkg::B_SRC:  t_src_q <= scale_sat(bfj_pkg::WIDE_W'(prod_s1), neg_s1, 1'b0);
			bfj_pkg::B_JL:   t_l_q   <= scale_sat(bfj_pkg::WIDE_W'(prod_s1), neg_s1, 1'b0);
			bfj_pkg::B_JR:   t_r_q   <= scale_sat(bfj_pkg::WIDE_W'(prod_s1), neg_s1, 1'b0);
			default: begin
			end
		endcase
		if (write_out) begin
			out_data_q.row_index <= job_q.idx;
			out_data_q.rhs_value <= rhs;
			out_data_q.jac_lower <= lower;
			out_data_q.jac_diag  <= diag;
			out_data_q.jac_upper <= upper;
			out_data_q.row_last  <= job_q.fin;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

// ===== design/burgers_fd_rhs_jacobian_row_unit.sv =====
// Top level of the periodic viscous Burgers right-hand-side and Jacobian row unit.
//
// Grid points (u, e, last mark) enter in index order; for each point i of the
// periodic vector the unit returns rhs = dg*lap(u) - ag*(u[i+1]^2 - u[i-1]^2)
// - sg*e[i] and the tridiagonal row of I - dt*theta*J, all Q16.16, saturated.
// Row i comes out when point i+1 arrives; the point that closes the vector
// releases row m-2, row m-1 and then row 0, which carries row_last. A point at
// index MAX_POINTS-1 closes the vector by itself. The front end takes a point
// and then holds in_stall while it issues the rows of that point (zero to
// three), longer if the four-entry job queue is full. The back end works on
// one row at a time: all eight products go through one shared 34x32
// multiplier, one per cycle, scaled in the cycle after. It pops the next job
// only once the last row is written to the result register. The result
// register lets the next row be computed while the last one is stalled.
// There is no clearing pass after reset. Gains are written over APB at byte
// address 4*i, and may be changed only while no rows are in flight.
module burgers_fd_rhs_jacobian_row_unit (
	input  logic                         clk,
	input  logic                         arst_n,
	// point request channel
	input  logic                         in_valid,
	output logic                         in_stall,
	input  bfj_pkg::in_item_t            in_data,
	// row request channel
	output logic                         out_valid,
	input  logic                         out_stall,
	output bfj_pkg::out_item_t           out_data,
	// configuration
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [bfj_pkg::ADDR_W-1:0]   paddr,
	input  logic [bfj_pkg::PDATA_W-1:0]  pwdata,
	output logic [bfj_pkg::PDATA_W-1:0]  prdata,
	output logic                         pready
);

	bfj_pkg::gains_t        gains_q;
	bfj_pkg::reg_index_t    reg_idx;
	logic                   cfg_write;
	logic                   q_push, q_pop;
	bfj_pkg::job_t          push_job, q_head;
	bfj_pkg::queue_status_t q_status;

	// ---- configuration registers ----
	// Zero-wait APB: the access phase always completes. Register index is
	// taken from the word address; undefined slots read zero and drop writes.
	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite;
	assign reg_idx   = bfj_pkg::reg_index_t'(paddr[bfj_pkg::ADDR_W-1:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gains_q <= '0;
		end else if (cfg_write) begin
			case (reg_idx)
				bfj_pkg::REG_DIFF_GAIN:
					gains_q.diff_gain <= pwdata[bfj_pkg::GAIN_W-1:0];
				bfj_pkg::REG_ADV_GAIN:
					gains_q.adv_gain <= pwdata[bfj_pkg::GAIN_W-1:0];
				bfj_pkg::REG_STEP_GAIN:
					gains_q.step_gain <= pwdata[bfj_pkg::GAIN_W-1:0];
				bfj_pkg::REG_JAC_DIFF_GAIN:
					gains_q.jac_diff_gain <= pwdata[bfj_pkg::GAIN_W-1:0];
				bfj_pkg::REG_JAC_ADV_GAIN:
					gains_q.jac_adv_gain <= pwdata[bfj_pkg::GAIN_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			bfj_pkg::REG_DIFF_GAIN:     prdata = bfj_pkg::PDATA_W'(gains_q.diff_gain);
			bfj_pkg::REG_ADV_GAIN:      prdata = bfj_pkg::PDATA_W'(gains_q.adv_gain);
			bfj_pkg::REG_STEP_GAIN:     prdata = bfj_pkg::PDATA_W'(gains_q.step_gain);
			bfj_pkg::REG_JAC_DIFF_GAIN: prdata = bfj_pkg::PDATA_W'(gains_q.jac_diff_gain);
			bfj_pkg::REG_JAC_ADV_GAIN:  prdata = bfj_pkg::PDATA_W'(gains_q.jac_adv_gain);
			default:                    prdata = '0;
		endcase
	end

	// ---- front end: window and wrap bookkeeping, one job per row ----
	bfj_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_data  (in_data),
		.q_status (q_status),
		.push     (q_push),
		.push_job (push_job)
	);

	// ---- job queue: decouples point intake from row arithmetic ----
	bfj_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_job (push_job),
		.pop      (q_pop),
		.head     (q_head),
		.status   (q_status)
	);

	// ---- back end: multiply sequencer, saturation, result register ----
	bfj_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.gains     (gains_q),
		.q_head    (q_head),
		.q_status  (q_status),
		.q_pop     (q_pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

endmodule

// ===== design/bfj_checker.sv =====
// Port-level checker of the row unit and its bind to the top level.
`include "burgers_fd_rhs_jacobian_row_unit_assert.svh"

module bfj_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         out_valid,
	input logic                         out_stall,
	input bfj_pkg::out_item_t           out_data,
	input logic                         psel,
	input logic                         penable,
	input logic                         pwrite,
	input logic [bfj_pkg::ADDR_W-1:0]   paddr,
	input logic [bfj_pkg::PDATA_W-1:0]  pwdata,
	input logic [bfj_pkg::PDATA_W-1:0]  prdata
);

	`BFJ_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data), "stalled row request changed")

	`BFJ_ASSERT_NOW(a_last_is_row0, out_valid && out_data.row_last, out_data.row_index == '0, "row_last on a row other than 0")

	`BFJ_ASSERT_NOW(a_diag_range, out_valid, (out_data.jac_diag >= bfj_pkg::ONE_Q16) && (out_data.jac_diag[bfj_pkg::VALUE_W-1:25] == '0), "diagonal outside 1 + 2*jd range")

	`BFJ_ASSERT_NOW(a_cfg_readback, $past(psel && penable && pwrite && (paddr == '0)) && psel && !pwrite && (paddr == '0), prdata == bfj_pkg::PDATA_W'($past(pwdata[bfj_pkg::GAIN_W-1:0])), "diffusion gain readback mismatch")

endmodule

bind burgers_fd_rhs_jacobian_row_unit bfj_checker u_bfj_checker (.*);
